// ===== design/kct_pkg.sv =====
`default_nettype none

package kct_pkg;

    // k-mer split: high bits pick the page map entry, low bits the counter in the page
    localparam int MAP_IDX_W   = 10;
    localparam int SLOT_IDX_W  = 10;
    localparam int MAX_PAGES   = 16;
    localparam int COUNT_BITS  = 32;
    localparam int CFG_W       = 5;
    localparam int LIMIT_RESET = 16;

    localparam int KMER_BITS   = MAP_IDX_W + SLOT_IDX_W;
    localparam int NUM_PREFIX  = 1 << MAP_IDX_W;
    localparam int PAGE_SIZE   = 1 << SLOT_IDX_W;
    localparam int PAGE_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int USED_W      = $clog2(MAX_PAGES + 1);
    localparam int CMP_W       = (USED_W > CFG_W) ? USED_W : CFG_W;
    localparam int CNT_DEPTH   = MAX_PAGES * PAGE_SIZE;
    localparam int CNT_AW      = PAGE_W + SLOT_IDX_W;
    localparam int CLR_DEPTH   = (NUM_PREFIX > CNT_DEPTH) ? NUM_PREFIX : CNT_DEPTH;
    localparam int CLR_W       = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic {
        STAT_OK      = 1'b0,
        STAT_NO_ROOM = 1'b1
    } t_status;

    typedef struct packed {
        t_op                  op;
        logic [KMER_BITS-1:0] kmer;
    } t_req;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        t_status               status;
        logic [COUNT_BITS-1:0] peak_count;
        logic [KMER_BITS-1:0]  max_kmer;
    } t_res;

    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
    } t_map_entry;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_CNT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic map_step;
        logic cnt_step;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic need_cnt;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/kct_ctrl.sv =====
`default_nettype none

module kct_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire kct_pkg::t_sts i_sts,
    output kct_pkg::t_cmd     o_cmd,
    output logic              o_busy
);

    kct_pkg::t_state r_state;
    kct_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kct_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kct_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = kct_pkg::ST_IDLE;
                end
            end
            kct_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = kct_pkg::ST_MAP;
                end
            end
            kct_pkg::ST_MAP: begin
                n_state = i_sts.need_cnt ? kct_pkg::ST_CNT : kct_pkg::ST_IDLE;
            end
            kct_pkg::ST_CNT: begin
                n_state = kct_pkg::ST_IDLE;
            end
            default: begin
                n_state = kct_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            kct_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            kct_pkg::ST_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            kct_pkg::ST_MAP: begin
                o_cmd.map_step = 1'b1;
            end
            kct_pkg::ST_CNT: begin
                o_cmd.cnt_step = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/kct_datapath.sv =====
`default_nettype none

module kct_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire kct_pkg::t_cmd               i_cmd,
    input  wire kct_pkg::t_req               i_req,
    input  wire logic                        i_cfg_we,
    input  wire logic [kct_pkg::CFG_W-1:0]   i_cfg_data,
    output kct_pkg::t_sts                    o_sts,
    output kct_pkg::t_res                    o_res,
    output logic                             o_done
);

    kct_pkg::t_map_entry mem_map [kct_pkg::NUM_PREFIX];
    logic [kct_pkg::COUNT_BITS-1:0] mem_cnt [kct_pkg::CNT_DEPTH];

    logic [kct_pkg::CLR_W-1:0]      r_clr_addr;
    kct_pkg::t_req                  r_req;
    kct_pkg::t_map_entry            r_map_rd;
    logic [kct_pkg::COUNT_BITS-1:0] r_cnt_rd;
    logic [kct_pkg::CNT_AW-1:0]     r_cnt_addr;
    logic [kct_pkg::USED_W-1:0]     r_pages_used;
    logic [kct_pkg::CFG_W-1:0]      r_page_limit;
    logic [kct_pkg::COUNT_BITS-1:0] r_best_count;
    logic [kct_pkg::KMER_BITS-1:0]  r_best_kmer;
    kct_pkg::t_res                  r_res;
    logic                           r_done;

    logic [kct_pkg::MAP_IDX_W-1:0]   req_prefix;
    logic [kct_pkg::MAP_IDX_W-1:0]   cur_prefix;
    logic [kct_pkg::SLOT_IDX_W-1:0]  cur_suffix;
    logic [kct_pkg::CMP_W-1:0]       eff_limit;
    logic                            room;
    logic                            alloc;
    logic [kct_pkg::PAGE_W-1:0]      sel_page;
    logic [kct_pkg::CNT_AW-1:0]      rd_addr;
    logic [kct_pkg::COUNT_BITS-1:0]  cnt_inc;
    logic                            new_best;
    logic                            clr_map_en;
    logic                            clr_cnt_en;
    logic                            cnt_we;

    assign req_prefix = i_req.kmer[kct_pkg::KMER_BITS-1:kct_pkg::SLOT_IDX_W];
    assign cur_prefix = r_req.kmer[kct_pkg::KMER_BITS-1:kct_pkg::SLOT_IDX_W];
    assign cur_suffix = r_req.kmer[kct_pkg::SLOT_IDX_W-1:0];

    // clamp the limit to the page capacity
    assign eff_limit = (kct_pkg::CMP_W'(r_page_limit) > kct_pkg::CMP_W'(kct_pkg::MAX_PAGES))
                     ? kct_pkg::CMP_W'(kct_pkg::MAX_PAGES) : kct_pkg::CMP_W'(r_page_limit);
    assign room      = kct_pkg::CMP_W'(r_pages_used) < eff_limit;
    assign alloc     = (r_req.op == kct_pkg::OP_ADD) && !r_map_rd.valid && room;
    assign sel_page  = r_map_rd.valid ? r_map_rd.page : kct_pkg::PAGE_W'(r_pages_used);
    assign rd_addr   = {sel_page, cur_suffix};

    assign cnt_inc   = (r_cnt_rd == '1) ? r_cnt_rd : r_cnt_rd + kct_pkg::COUNT_BITS'(1);
    assign new_best  = cnt_inc > r_best_count;

    // compare one bit wider so a depth equal to 2**CLR_W does not wrap to zero
    assign clr_map_en = i_cmd.clr_step &&
                        ({1'b0, r_clr_addr} < (kct_pkg::CLR_W+1)'(kct_pkg::NUM_PREFIX));
    assign clr_cnt_en = i_cmd.clr_step &&
                        ({1'b0, r_clr_addr} < (kct_pkg::CLR_W+1)'(kct_pkg::CNT_DEPTH));
    assign cnt_we     = i_cmd.cnt_step && (r_req.op == kct_pkg::OP_ADD);

    assign o_sts.clr_last = (r_clr_addr == kct_pkg::CLR_W'(kct_pkg::CLR_DEPTH - 1));
    assign o_sts.need_cnt = r_map_rd.valid || alloc;
    assign o_res  = r_res;
    assign o_done = r_done;

    // page map: clear sweep, allocation write, registered read on accept
    always_ff @(posedge i_clk) begin
        if (clr_map_en) begin
            mem_map[r_clr_addr[kct_pkg::MAP_IDX_W-1:0]] <= '0;
        end else if (i_cmd.map_step && alloc) begin
            mem_map[cur_prefix] <= '{valid: 1'b1, page: kct_pkg::PAGE_W'(r_pages_used)};
        end
        if (i_cmd.accept) begin
            r_map_rd <= mem_map[req_prefix];
        end
    end

    // counter store: clear sweep, write back, registered read in the map phase
    always_ff @(posedge i_clk) begin
        if (clr_cnt_en) begin
            mem_cnt[r_clr_addr[kct_pkg::CNT_AW-1:0]] <= '0;
        end else if (cnt_we) begin
            mem_cnt[r_cnt_addr] <= cnt_inc;
        end
        if (i_cmd.map_step) begin
            r_cnt_rd <= mem_cnt[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
        end
        if (i_cmd.map_step) begin
            r_cnt_addr <= rd_addr;
        end
        if (i_cmd.map_step && !o_sts.need_cnt) begin
            r_res.count      <= '0;
            r_res.status     <= (r_req.op == kct_pkg::OP_ADD) ? kct_pkg::STAT_NO_ROOM
                                                              : kct_pkg::STAT_OK;
            r_res.peak_count <= r_best_count;
            r_res.max_kmer   <= r_best_kmer;
        end else if (i_cmd.cnt_step) begin
            r_res.status <= kct_pkg::STAT_OK;
            if (r_req.op == kct_pkg::OP_ADD) begin
                r_res.count      <= cnt_inc;
                r_res.peak_count <= new_best ? cnt_inc : r_best_count;
                r_res.max_kmer   <= new_best ? r_req.kmer : r_best_kmer;
            end else begin
                r_res.count      <= r_cnt_rd;
                r_res.peak_count <= r_best_count;
                r_res.max_kmer   <= r_best_kmer;
            end
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_pages_used <= '0;
            r_page_limit <= kct_pkg::CFG_W'(kct_pkg::LIMIT_RESET);
            r_best_count <= '0;
            r_best_kmer  <= '0;
            r_done       <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + kct_pkg::CLR_W'(1);
            end
            if (i_cfg_we) begin
                r_page_limit <= i_cfg_data;
            end
            if (i_cmd.map_step && alloc) begin
                r_pages_used <= r_pages_used + kct_pkg::USED_W'(1);
            end
            if (cnt_we && new_best) begin
                r_best_count <= cnt_inc;
                r_best_kmer  <= r_req.kmer;
            end
            r_done <= (i_cmd.map_step && !o_sts.need_cnt) || i_cmd.cnt_step;
        end
    end

endmodule

`default_nettype wire

// ===== design/kmer_count_table_top.sv =====
`default_nettype none

// Two-level paged k-mer counter. After reset the block runs a clearing pass
// over its stores, to the depth of the counter store, holding o_busy high;
// configuration writes are taken during that pass. A request is taken at a
// rising edge with i_start high and o_busy low. A request whose page is
// present, or an add that allocates a page, reads the page map at the
// request edge and the counter in the page map phase, then ends with the
// counter phase; o_done then pulses for one cycle and o_busy drops with it,
// so a new request is taken only after the last is done. A query of a
// missing page, or an add refused for lack of room, ends after the page map
// phase. There is no output back-pressure: the result is on o_res while
// o_done is high and is held until the next result, so capture it in that
// cycle. The page limit register is written through i_cfg_valid/o_cfg_ready;
// write it only while the block is idle.
module kmer_count_table_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire kct_pkg::t_req               i_req,
    output logic                             o_busy,
    output logic                             o_done,
    output kct_pkg::t_res                    o_res,
    input  wire logic                        i_cfg_valid,
    input  wire logic [kct_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                             o_cfg_ready
);

    kct_pkg::t_cmd cmd;
    kct_pkg::t_sts sts;

    // the limit register can always take a write
    assign o_cfg_ready = 1'b1;

    // sequence clear pass, page map phase and counter phase
    kct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // hold the stores, page allocation, saturating counters and the maximum
    kct_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_res      (o_res),
        .o_done     (o_done)
    );

`ifndef SYNTHESIS
    // a taken request makes the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> o_busy)
        else $error("request taken but block not busy afterwards");

    // a result comes only from the end of a page map or counter phase
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(cmd.map_step) && !$past(sts.need_cnt)) || $past(cmd.cnt_step))
        else $error("result strobe without a finished request");

    // a refused add reports a zero count
    a_no_room_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == kct_pkg::STAT_NO_ROOM) |-> o_res.count == '0)
        else $error("refused add with nonzero count");

    // the result never shows a count above the tracked maximum
    a_count_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_res.count <= o_res.peak_count)
        else $error("count above reported maximum");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Tracks the paged k-mer counts the block should hold and checks each
    // result against the oldest outstanding expectation.
    class kmer_tally;
        int unsigned                  mismatches;
        kct_pkg::t_res                expected_results[$];
        bit [kct_pkg::CFG_W-1:0]      page_limit;
        bit                           map_valid [kct_pkg::NUM_PREFIX];
        bit [kct_pkg::PAGE_W-1:0]     map_page  [kct_pkg::NUM_PREFIX];
        int unsigned                  pages_used;
        bit [kct_pkg::COUNT_BITS-1:0] counters  [kct_pkg::CNT_DEPTH];
        bit [kct_pkg::COUNT_BITS-1:0] best_count;
        bit [kct_pkg::KMER_BITS-1:0]  best_kmer;

        function new();
            page_limit = kct_pkg::CFG_W'(kct_pkg::LIMIT_RESET);
        endfunction

        function void set_page_limit(bit [kct_pkg::CFG_W-1:0] value);
            page_limit = value;
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Apply one accepted request to the shadow tables and queue its result.
        function void note_request(kct_pkg::t_req req);
            kct_pkg::t_res                  res;
            int unsigned                    lim;
            bit [kct_pkg::MAP_IDX_W-1:0]    prefix;
            bit [kct_pkg::SLOT_IDX_W-1:0]   suffix;
            bit [kct_pkg::CNT_AW-1:0]       addr;
            bit [kct_pkg::COUNT_BITS-1:0]   c;
            prefix = req.kmer[kct_pkg::KMER_BITS-1:kct_pkg::SLOT_IDX_W];
            suffix = req.kmer[kct_pkg::SLOT_IDX_W-1:0];
            res.count  = '0;
            res.status = kct_pkg::STAT_OK;
            if (req.op == kct_pkg::OP_ADD) begin
                lim = (page_limit > kct_pkg::MAX_PAGES) ? kct_pkg::MAX_PAGES : page_limit;
                if (!map_valid[prefix] && pages_used < lim) begin
                    map_valid[prefix] = 1'b1;
                    map_page[prefix]  = pages_used[kct_pkg::PAGE_W-1:0];
                    pages_used++;
                end
                if (!map_valid[prefix]) begin
                    res.status = kct_pkg::STAT_NO_ROOM;
                end else begin
                    addr = {map_page[prefix], suffix};
                    c = counters[addr];
                    if (c != '1)
                        c++;
                    counters[addr] = c;
                    res.count = c;
                    if (c > best_count) begin
                        best_count = c;
                        best_kmer  = req.kmer;
                    end
                end
            end else if (map_valid[prefix]) begin
                addr = {map_page[prefix], suffix};
                res.count = counters[addr];
            end
            res.peak_count = best_count;
            res.max_kmer   = best_kmer;
            expected_results.push_back(res);
        endfunction

        task check_result(kct_pkg::t_res got);
            kct_pkg::t_res want;
            if (expected_results.size() == 0) begin
                report("result with no request outstanding");
            end else begin
                want = expected_results.pop_front();
                if (got.count !== want.count)
                    report($sformatf("count %0d, want %0d", got.count, want.count));
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.peak_count !== want.peak_count)
                    report($sformatf("peak count %0d, want %0d",
                                     got.peak_count, want.peak_count));
                if (got.max_kmer !== want.max_kmer)
                    report($sformatf("max_kmer %05h, want %05h",
                                     got.max_kmer, want.max_kmer));
            end
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_start;
    kct_pkg::t_req               i_req;
    logic                        o_busy;
    logic                        o_done;
    kct_pkg::t_res               o_res;
    logic                        i_cfg_valid;
    logic [kct_pkg::CFG_W-1:0]   i_cfg_data;
    logic                        o_cfg_ready;

    kmer_tally          sb;

    // Small pools of prefixes and suffixes so that counts climb and pages fill.
    bit [kct_pkg::MAP_IDX_W-1:0]  prefix_pool [24];
    bit [kct_pkg::SLOT_IDX_W-1:0] suffix_pool [8];

    kmer_count_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #5 i_clk = ~i_clk;

    // Sample everything at the rising edge, before the block updates its outputs.
    // Check a result first, then note a request taken at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_result(o_res);
            if (i_start && !o_busy)
                sb.note_request(i_req);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_page_limit(i_cfg_data);
        end
    end

    // Present one request and hold it until the block takes it. Leave i_start
    // high afterwards: the next call or a gap decides whether to drop it.
    task automatic send_request(kct_pkg::t_op op, logic [kct_pkg::KMER_BITS-1:0] kmer);
        i_start   <= 1'b1;
        i_req.op   <= op;
        i_req.kmer <= kmer;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Drop start for a random number of cycles, or none at all.
    task automatic sender_gap(int pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct && n < 40)
            n++;
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold off until every outstanding request has returned, then let the pipeline settle.
    task automatic drain;
        i_start <= 1'b0;
        do @(posedge i_clk); while (sb.expected_results.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_page_limit(logic [kct_pkg::CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly pooled k-mers so counts build up on shared counters; the rest
    // spray the whole code space to exercise every bit and allocation.
    function automatic kct_pkg::t_req make_request();
        kct_pkg::t_req r;
        r.op = ($urandom_range(99) < 30) ? kct_pkg::OP_QUERY : kct_pkg::OP_ADD;
        if ($urandom_range(99) < 75)
            r.kmer = {prefix_pool[$urandom_range(23)], suffix_pool[$urandom_range(7)]};
        else
            r.kmer = kct_pkg::KMER_BITS'($urandom());
        return r;
    endfunction

    task automatic run_phase(int n_items, int idle_pct);
        kct_pkg::t_req r;
        for (int i = 0; i < n_items; i++) begin
            sender_gap(idle_pct);
            // Occasionally let the block run completely dry mid-phase.
            if ($urandom_range(99) < 2)
                drain();
            r = make_request();
            send_request(r.op, r.kmer);
        end
    endtask

    initial begin
        int waited;
        sb = new();
        foreach (prefix_pool[i])
            prefix_pool[i] = kct_pkg::MAP_IDX_W'($urandom_range(kct_pkg::NUM_PREFIX - 1));
        foreach (suffix_pool[i])
            suffix_pool[i] = kct_pkg::SLOT_IDX_W'($urandom_range(kct_pkg::PAGE_SIZE - 1));

        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No pages allowed: every add is refused, queries see a missing page.
        // The first request also waits out the clearing pass.
        write_page_limit(5'd0);
        send_request(kct_pkg::OP_ADD,   20'h00000);
        send_request(kct_pkg::OP_QUERY, 20'h00000);
        send_request(kct_pkg::OP_ADD,   20'hFFFFF);
        drain();

        // Two pages: fill them from both ends of the prefix and suffix range,
        // then run into the limit.
        write_page_limit(5'd2);
        send_request(kct_pkg::OP_ADD,   20'h00000);
        send_request(kct_pkg::OP_ADD,   20'hFFFFF);
        send_request(kct_pkg::OP_ADD,   20'h003FF);
        send_request(kct_pkg::OP_ADD,   20'hFFC00);
        send_request(kct_pkg::OP_ADD,   20'h00000);
        send_request(kct_pkg::OP_ADD,   20'h12345);
        send_request(kct_pkg::OP_QUERY, 20'hFFFFF);
        send_request(kct_pkg::OP_QUERY, 20'h12345);
        send_request(kct_pkg::OP_QUERY, 20'h00000);
        drain();

        // Lowered limit: existing pages keep counting, new ones are refused.
        // A tie with the best count must not move the best k-mer.
        write_page_limit(5'd1);
        send_request(kct_pkg::OP_ADD,   20'hFFFFF);
        send_request(kct_pkg::OP_ADD,   20'h55555);
        send_request(kct_pkg::OP_ADD,   20'hFFFFF);
        send_request(kct_pkg::OP_QUERY, 20'hAAAAA);
        drain();

        // Limit above capacity acts as the full page count.
        write_page_limit(5'd31);
        send_request(kct_pkg::OP_ADD,   20'h55555);
        send_request(kct_pkg::OP_ADD,   20'hAAAAA);
        send_request(kct_pkg::OP_QUERY, 20'h55555);
        send_request(kct_pkg::OP_QUERY, 20'hAAAAA);
        send_request(kct_pkg::OP_ADD,   20'h55555);
        drain();

        // Random traffic under three limits and three sender idle rates.
        write_page_limit(5'd6);
        run_phase(150, 24);
        drain();
        write_page_limit(5'd16);
        run_phase(150, 79);
        drain();
        write_page_limit(5'd31);
        run_phase(150, 0);

        // Wait for the tail to come back, with a bound.
        i_start <= 1'b0;
        waited = 0;
        while (sb.expected_results.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (5) @(posedge i_clk);
        if (sb.expected_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_results.size()));

        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest legal run, clearing pass included.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/kct_pkg.sv
design/kct_ctrl.sv
design/kct_datapath.sv
design/kmer_count_table_top.sv
bench/tb.sv
